/* rtl/hmio_pkg.sv */
// ============================================================================
// hmio_pkg
// Shared constants, address map and read-side register rules for the
// internal work RAM / high area block.
// ============================================================================
package hmio_pkg;

    // Storage geometry
    localparam int WORK_RAM_BYTES = 8192;
    localparam int WRAM_AW        = $clog2(WORK_RAM_BYTES);
    localparam int HIGH_BYTES     = 512;
    localparam int HRAM_AW        = $clog2(HIGH_BYTES);
    localparam int DATA_W         = 8;

    // OAM DMA: byte count and the width of the offset within a source page
    localparam int DMA_LENGTH     = 160;
    localparam int DMA_CW         = 8;

    // Bus map
    localparam logic [15:0] RAM_BASE    = 16'hC000;
    localparam logic [15:0] HIGH_BASE   = 16'hFE00;
    localparam logic [15:0] OAM_GAP_LO  = 16'hFEA0;
    localparam logic [15:0] OAM_GAP_HI  = 16'hFEFF;

    // I/O registers with special behavior
    localparam logic [15:0] ADDR_JOYP   = 16'hFF00;
    localparam logic [15:0] ADDR_UNUSED = 16'hFF03;
    localparam logic [15:0] ADDR_DIV    = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA   = 16'hFF05;
    localparam logic [15:0] ADDR_TMA    = 16'hFF06;
    localparam logic [15:0] ADDR_TAC    = 16'hFF07;
    localparam logic [15:0] UNUSED_LO   = 16'hFF08;
    localparam logic [15:0] UNUSED_HI   = 16'hFF0E;
    localparam logic [15:0] ADDR_NR11   = 16'hFF11;
    localparam logic [15:0] ADDR_NR14   = 16'hFF14;
    localparam logic [15:0] ADDR_NR21   = 16'hFF16;
    localparam logic [15:0] ADDR_NR24   = 16'hFF19;
    localparam logic [15:0] ADDR_NR30   = 16'hFF1A;
    localparam logic [15:0] ADDR_NR32   = 16'hFF1C;
    localparam logic [15:0] ADDR_NR34   = 16'hFF1E;
    localparam logic [15:0] ADDR_NR44   = 16'hFF23;
    localparam logic [15:0] ADDR_STAT   = 16'hFF41;
    localparam logic [15:0] ADDR_LY     = 16'hFF44;
    localparam logic [15:0] ADDR_DMA    = 16'hFF46;

    // Masks
    localparam logic [7:0] MASK_DUTY    = 8'hC0;
    localparam logic [7:0] MASK_LENEN   = 8'h40;
    localparam logic [7:0] MASK_VOL     = 8'h60;
    localparam logic [7:0] STAT_FORCE   = 8'h80;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam logic [7:0] JOYP_HI_MASK = 8'hF0;
    localparam logic [7:0] TAC_MASK     = 8'h07;

    // Command kinds
    typedef enum logic [1:0] {
        MODE_READ     = 2'd0,
        MODE_WRITE    = 2'd1,
        MODE_DIV_INC  = 2'd2,
        MODE_JOYP_SET = 2'd3
    } mode_t;

    // Read value of a high-area byte (address at or above HIGH_BASE)
    function automatic logic [7:0] high_read(input logic [15:0] addr,
                                             input logic [7:0]  stored,
                                             input logic [7:0]  buttons,
                                             input logic [7:0]  directions);
        logic [7:0] b;
        b = stored;
        if (addr >= OAM_GAP_LO && addr <= OAM_GAP_HI) begin
            b = 8'h00;
        end
        else begin
            unique case (addr) inside
                ADDR_JOYP:
                begin
                    if (!stored[5])
                        b = buttons;
                    else if (!stored[4])
                        b = directions;
                end
                ADDR_UNUSED, [UNUSED_LO:UNUSED_HI]:
                    b = OPEN_BUS;
                ADDR_NR11, ADDR_NR21, ADDR_NR30:
                    b = stored & MASK_DUTY;
                ADDR_NR14, ADDR_NR24, ADDR_NR34, ADDR_NR44:
                    b = stored & MASK_LENEN;
                ADDR_NR32:
                    b = stored & MASK_VOL;
                ADDR_STAT:
                    b = stored | STAT_FORCE;
                default:
                    b = stored;
            endcase
        end
        return b;
    endfunction

endpackage

/* rtl/hmio_ram.sv */
// ============================================================================
// hmio_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ============================================================================
module hmio_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/handheld_internal_memory_io_block_core.sv */
// ============================================================================
// handheld_internal_memory_io_block_core
// Work RAM, echo, OAM / I/O / high RAM of an 8-bit handheld memory map.
// ============================================================================
// Usage:
//   Commands arrive on the s_* stream, one word per bus access or event:
//   s_tuser carries the kind (read, write, divider increment, joypad store),
//   s_tdata the address, write byte and the two joypad rows. Every command
//   returns exactly one word on the m_* stream: the read byte in m_tdata,
//   the in-range and timer-restart flags in m_tuser.
//
//   Sequence: a plain read or write goes from acceptance through the look-up
//   and finish steps back to idle; the result passes through res_data_reg to
//   the output register. A write to FF07 that changes the rate adds the TMA
//   and TAC steps. A write to FF46 runs the OAM DMA, one read from the source
//   and one write into OAM per byte, for DMA_LENGTH (160) bytes.
//
//   After reset the block sweeps both RAMs to zero, one entry per cycle,
//   over all WORK_RAM_BYTES (8192) entries; s_tready stays low until done.
//   A new command is accepted while an earlier result still waits in the
//   output register; if the receiver stalls, the block holds the next
//   result in its finish step until the output register drains.
// ============================================================================
module handheld_internal_memory_io_block_core (
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] address, [23:16] write_data, [31:24] button_keys,
    // [39:32] direction_keys
    input  logic [39:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data
    output logic [7:0]  m_tdata,
    // [0] in_range, [1] timer_restart
    output logic [1:0]  m_tuser
);

    localparam int WAW = hmio_pkg::WRAM_AW;
    localparam int HAW = hmio_pkg::HRAM_AW;
    localparam int CW  = hmio_pkg::DMA_CW;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOOK   = 8'b0000_0100,
        ST_TMA    = 8'b0000_1000,
        ST_TAC_WR = 8'b0001_0000,
        ST_DMA_RD = 8'b0010_0000,
        ST_DMA_WR = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [WAW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]     dma_cnt_reg, dma_cnt_next;

    // latched command
    hmio_pkg::mode_t   mode_reg;
    logic [15:0]       addr_reg;
    logic [7:0]        data_reg;
    logic [7:0]        btn_reg;
    logic [7:0]        dir_reg;

    logic [7:0]        res_data_reg, res_data_next;
    logic              restart_reg, restart_next;

    logic              m_tvalid_reg;
    logic [7:0]        out_data_reg;
    logic              out_inr_reg;
    logic              out_restart_reg;

    // RAM ports
    logic              wram_we;
    logic [WAW-1:0]    wram_waddr, wram_raddr;
    logic [7:0]        wram_wdata, wram_rdata;
    logic              hram_we;
    logic [HAW-1:0]    hram_waddr, hram_raddr;
    logic [7:0]        hram_wdata, hram_rdata;

    logic              accept;
    logic              load_out;
    logic              in_bus, in_high, in_gap;
    logic [15:0]       dma_src;
    logic [15:0]       in_addr;
    hmio_pkg::mode_t   in_mode;

    assign in_addr  = s_tdata[15:0];
    assign in_mode  = hmio_pkg::mode_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_bus   = (addr_reg >= hmio_pkg::RAM_BASE);
    assign in_high  = (addr_reg >= hmio_pkg::HIGH_BASE);
    assign in_gap   = (addr_reg >= hmio_pkg::OAM_GAP_LO) && (addr_reg <= hmio_pkg::OAM_GAP_HI);

    // DMA source: page from the written byte, offset from the byte counter
    assign dma_src  = {data_reg, dma_cnt_reg};

    assign load_out = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    hmio_ram #(.ADDR_W(WAW), .DATA_W(hmio_pkg::DATA_W)) u_wram (
        .clk   (clk),
        .we    (wram_we),
        .waddr (wram_waddr),
        .wdata (wram_wdata),
        .raddr (wram_raddr),
        .rdata (wram_rdata)
    );

    hmio_ram #(.ADDR_W(HAW), .DATA_W(hmio_pkg::DATA_W)) u_hram (
        .clk   (clk),
        .we    (hram_we),
        .waddr (hram_waddr),
        .wdata (hram_wdata),
        .raddr (hram_raddr),
        .rdata (hram_rdata)
    );

    // Sequencer. Reads are issued one state ahead of the state that uses
    // the data; no state writes an entry that the same cycle reads, so the
    // read-modify-write steps need no forwarding.
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        dma_cnt_next  = dma_cnt_reg;
        res_data_next = res_data_reg;
        restart_next  = restart_reg;

        wram_we       = 1'b0;
        wram_waddr    = addr_reg[WAW-1:0];
        wram_wdata    = data_reg;
        wram_raddr    = in_addr[WAW-1:0];
        hram_we       = 1'b0;
        hram_waddr    = addr_reg[HAW-1:0];
        hram_wdata    = data_reg;
        hram_raddr    = in_addr[HAW-1:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero both RAMs, the high area during the first rows
                wram_we    = 1'b1;
                wram_waddr = clr_cnt_reg;
                wram_wdata = 8'h00;
                hram_we    = (clr_cnt_reg < WAW'(hmio_pkg::HIGH_BYTES));
                hram_waddr = clr_cnt_reg[HAW-1:0];
                hram_wdata = 8'h00;
                clr_cnt_next = clr_cnt_reg + WAW'(1);
                if (clr_cnt_reg == WAW'(hmio_pkg::WORK_RAM_BYTES - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                // look up the entry the command touches
                if (in_mode == hmio_pkg::MODE_DIV_INC)
                    hram_raddr = hmio_pkg::ADDR_DIV[HAW-1:0];
                else if (in_mode == hmio_pkg::MODE_JOYP_SET)
                    hram_raddr = hmio_pkg::ADDR_JOYP[HAW-1:0];
                restart_next  = 1'b0;
                res_data_next = 8'h00;
                if (accept)
                    state_next = ST_LOOK;
            end

            ST_LOOK:
            begin
                state_next = ST_FINISH;
                unique case (mode_reg)
                    hmio_pkg::MODE_READ:
                    begin
                        if (!in_bus)
                            res_data_next = 8'h00;
                        else if (!in_high)
                            res_data_next = wram_rdata;
                        else
                            res_data_next = hmio_pkg::high_read(addr_reg, hram_rdata,
                                                                btn_reg, dir_reg);
                    end

                    hmio_pkg::MODE_WRITE:
                    begin
                        if (in_bus && !in_high) begin
                            wram_we = 1'b1;
                        end
                        else if (in_high && !in_gap) begin
                            unique case (addr_reg)
                                hmio_pkg::ADDR_DIV, hmio_pkg::ADDR_LY:
                                begin
                                    hram_we    = 1'b1;
                                    hram_wdata = 8'h00;
                                end
                                hmio_pkg::ADDR_JOYP:
                                begin
                                    // keep the stored key nibble
                                    hram_we    = 1'b1;
                                    hram_wdata = (data_reg & hmio_pkg::JOYP_HI_MASK)
                                               | (hram_rdata & ~hmio_pkg::JOYP_HI_MASK);
                                end
                                hmio_pkg::ADDR_TAC:
                                begin
                                    if (hram_rdata[1:0] != data_reg[1:0]) begin
                                        // rate change: reload TIMA from TMA first
                                        hram_raddr = hmio_pkg::ADDR_TMA[HAW-1:0];
                                        state_next = ST_TMA;
                                    end
                                    else begin
                                        hram_we    = 1'b1;
                                        hram_wdata = data_reg & hmio_pkg::TAC_MASK;
                                    end
                                end
                                hmio_pkg::ADDR_DMA:
                                begin
                                    dma_cnt_next = '0;
                                    state_next   = ST_DMA_RD;
                                end
                                default:
                                begin
                                    hram_we = 1'b1;
                                end
                            endcase
                        end
                    end

                    hmio_pkg::MODE_DIV_INC:
                    begin
                        hram_we    = 1'b1;
                        hram_waddr = hmio_pkg::ADDR_DIV[HAW-1:0];
                        hram_wdata = hram_rdata + 8'd1;
                    end

                    hmio_pkg::MODE_JOYP_SET:
                    begin
                        hram_we    = 1'b1;
                        hram_waddr = hmio_pkg::ADDR_JOYP[HAW-1:0];
                    end

                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_TMA:
            begin
                hram_we      = 1'b1;
                hram_waddr   = hmio_pkg::ADDR_TIMA[HAW-1:0];
                hram_wdata   = hram_rdata;
                restart_next = 1'b1;
                state_next   = ST_TAC_WR;
            end

            ST_TAC_WR:
            begin
                hram_we    = 1'b1;
                hram_waddr = hmio_pkg::ADDR_TAC[HAW-1:0];
                hram_wdata = data_reg & hmio_pkg::TAC_MASK;
                state_next = ST_FINISH;
            end

            ST_DMA_RD:
            begin
                wram_raddr = dma_src[WAW-1:0];
                hram_raddr = dma_src[HAW-1:0];
                state_next = ST_DMA_WR;
            end

            ST_DMA_WR:
            begin
                // copy one source byte into OAM, open bus below work RAM
                hram_we    = 1'b1;
                hram_waddr = HAW'(dma_cnt_reg);
                if (dma_src < hmio_pkg::RAM_BASE)
                    hram_wdata = hmio_pkg::OPEN_BUS;
                else if (dma_src < hmio_pkg::HIGH_BASE)
                    hram_wdata = wram_rdata;
                else
                    hram_wdata = hmio_pkg::high_read(dma_src, hram_rdata, btn_reg, dir_reg);
                if (dma_cnt_reg == CW'(hmio_pkg::DMA_LENGTH - 1)) begin
                    state_next = ST_FINISH;
                end
                else begin
                    dma_cnt_next = dma_cnt_reg + CW'(1);
                    state_next   = ST_DMA_RD;
                end
            end

            ST_FINISH:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        dma_cnt_reg  <= dma_cnt_next;
        res_data_reg <= res_data_next;
        restart_reg  <= restart_next;
        if (accept) begin
            mode_reg <= in_mode;
            addr_reg <= in_addr;
            data_reg <= s_tdata[23:16];
            btn_reg  <= s_tdata[31:24];
            dir_reg  <= s_tdata[39:32];
        end
        if (load_out) begin
            out_data_reg    <= res_data_reg;
            out_inr_reg     <= in_bus && ((mode_reg == hmio_pkg::MODE_READ)
                                       || (mode_reg == hmio_pkg::MODE_WRITE));
            out_restart_reg <= restart_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_restart_reg, out_inr_reg};

endmodule

/* rtl/hmio_checker.sv */
// ============================================================================
// hmio_checker
// Port-level checks of the internal memory / I/O block, bound to its top.
// ============================================================================
module hmio_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    logic       s_hs, m_hs;
    logic [1:0] pend_reg;

    assign s_hs = s_tvalid && s_tready;
    assign m_hs = m_tvalid && m_tready;

    // words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else if (s_hs && !m_hs && pend_reg != 2'd3)
            pend_reg <= pend_reg + 2'd1;
        else if (!s_hs && m_hs && pend_reg != 2'd0)
            pend_reg <= pend_reg - 2'd1;
    end

    // no result without an outstanding command
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == 2'd0) |-> !m_tvalid)
        else $error("result word without an accepted command");

    // at most one result waiting and one command at work
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two commands outstanding");

    // a restart only comes from an in-range write
    a_restart_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> m_tuser[0])
        else $error("timer restart outside the handled range");

    // out-of-range accesses and non-bus commands read zero
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("nonzero data for an out-of-range result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind handheld_internal_memory_io_block_core hmio_checker u_hmio_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
